// File: hdl/odo_pkg.sv
package odo_pkg;

   // Field widths
   localparam int StepW   = 16;
   localparam int PosW    = 32;
   localparam int HeadW   = 20;
   localparam int PosExtW = PosW + 1;

   // Internal datapath widths
   localparam int SumW   = StepW + 1;      // right +/- left
   localparam int DangW  = 39;             // heading change, 2^-30 rad
   localparam int SumPW  = 38;             // wheel sum times distance gain, 2^-24 mm
   localparam int DistW  = 30;             // distance, 2^-16 mm
   localparam int HStepW = 25;             // heading step, 2^-16 rad
   localparam int ModW   = 38;             // remainder unit operand
   localparam int AngW   = 35;             // reduced direction angle, 2^-30 rad
   localparam int ZW     = 34;             // CORDIC angle accumulator
   localparam int XyW    = 32;             // CORDIC vector, Q2.30
   localparam int AtanW  = 30;
   localparam int AtanIdxW = 5;
   localparam int ProdW  = DistW + XyW;
   localparam int DispW  = 25;             // displacement, Q17.8 mm

   // Shifts of the fixed-point formats
   localparam int HeadFrac  = 14;
   localparam int DistShift = 8;
   localparam int DispShift = 38;

   // Remainder unit: restoring shift-subtract, quotient below 2^ModSteps
   localparam int ModSteps = 5;
   localparam int ModCntW  = 3;
   localparam int ModShift = ModSteps - 1;

   // CORDIC
   localparam int CordicIters = 16;
   localparam int AtanCount   = 24;
   localparam int CordicLast  = ((CordicIters < AtanCount) ? CordicIters : AtanCount) - 1;
   localparam int IterW       = $clog2(CordicLast + 1);

   // Constants
   localparam logic signed [22:0]      HeadStepK   = 23'sd2638337;
   localparam logic signed [21:0]      DistK       = 22'sd1082130;
   localparam logic [ModW-1:0]         TwoPiHead   = 38'd411775;
   localparam logic [ModW-1:0]         TwoPiAngle  = 38'd6746518852;
   localparam logic signed [AngW-1:0]  TwoPiA      = 35'sd6746518852;
   localparam logic signed [AngW-1:0]  PiA         = 35'sd3373259426;
   localparam logic signed [AngW-1:0]  HalfPiA     = 35'sd1686629713;
   localparam logic signed [XyW-1:0]   CordicStart = 32'sd652032874;
   localparam logic signed [PosW-1:0]  PosMax      = 32'sh7fffffff;
   localparam logic signed [PosW-1:0]  PosMin      = 32'sh80000000;
   localparam logic signed [HeadW-1:0] HeadMax     = 20'sd411774;

   typedef enum logic [0:0] {
      MOD_ANGLE   = 1'b0,
      MOD_HEADING = 1'b1
   } mod_sel_type;

   typedef struct packed {
      logic        start;
      mod_sel_type sel;
   } mod_cmd_type;

   typedef struct packed {
      logic                 start;
      logic signed [ZW-1:0] angle;
   } cordic_cmd_type;

   function automatic logic [AtanW-1:0] atan_at(input logic [AtanIdxW-1:0] idx);
      logic [AtanW-1:0] val;
      case (idx)
         5'd0: begin
            val = 30'd843314857;
         end
         5'd1: begin
            val = 30'd497837829;
         end
         5'd2: begin
            val = 30'd263043837;
         end
         5'd3: begin
            val = 30'd133525159;
         end
         5'd4: begin
            val = 30'd67021687;
         end
         5'd5: begin
            val = 30'd33543516;
         end
         5'd6: begin
            val = 30'd16775851;
         end
         5'd7: begin
            val = 30'd8388437;
         end
         5'd8: begin
            val = 30'd4194283;
         end
         5'd9: begin
            val = 30'd2097149;
         end
         5'd10: begin
            val = 30'd1048576;
         end
         5'd11: begin
            val = 30'd524288;
         end
         5'd12: begin
            val = 30'd262144;
         end
         5'd13: begin
            val = 30'd131072;
         end
         5'd14: begin
            val = 30'd65536;
         end
         5'd15: begin
            val = 30'd32768;
         end
         5'd16: begin
            val = 30'd16384;
         end
         5'd17: begin
            val = 30'd8192;
         end
         5'd18: begin
            val = 30'd4096;
         end
         5'd19: begin
            val = 30'd2048;
         end
         5'd20: begin
            val = 30'd1024;
         end
         5'd21: begin
            val = 30'd512;
         end
         5'd22: begin
            val = 30'd256;
         end
         5'd23: begin
            val = 30'd128;
         end
         default: begin
            val = '0;
         end
      endcase
      return val;
   endfunction

endpackage

// File: hdl/odo_if.sv
interface odo_req_if import odo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [StepW-1:0] right_steps;
   logic signed [StepW-1:0] left_steps;
   logic signed [PosW-1:0]  load_x;
   logic signed [PosW-1:0]  load_y;
   logic signed [HeadW-1:0] load_heading;

   modport source (
      output valid, func, right_steps, left_steps, load_x, load_y, load_heading,
      input  ready
   );
   modport sink (
      input  valid, func, right_steps, left_steps, load_x, load_y, load_heading,
      output ready
   );
endinterface

interface odo_rsp_if import odo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PosW-1:0]  pos_x;
   logic signed [PosW-1:0]  pos_y;
   logic signed [HeadW-1:0] heading;
   logic                    saturated;

   modport source (
      output valid, pos_x, pos_y, heading, saturated,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, heading, saturated,
      output ready
   );
endinterface

// File: hdl/odo_rem.sv
// Truncated remainder by one of two constant moduli, sign of the operand kept.
// One compare-subtract per cycle on the magnitude.
module odo_rem import odo_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  mod_cmd_type            cmd,
   input  logic signed [ModW-1:0] operand,
   output logic                   done,
   output logic signed [ModW-1:0] result
);

   logic [ModW-1:0]    rem_ff, rem_in;
   logic [ModW-1:0]    div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [ModCntW-1:0] cnt_ff, cnt_in;
   logic [ModW-1:0]    op_abs;

   assign op_abs = operand[ModW-1] ? ModW'(-operand) : ModW'(operand);

   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         rem_in = op_abs;
         neg_in = operand[ModW-1];
         div_in = (cmd.sel == MOD_ANGLE) ? (TwoPiAngle << ModShift) : (TwoPiHead << ModShift);
         cnt_in = ModCntW'(ModSteps);
      end else if (cnt_ff != '0) begin
         // subtract the shifted modulus where it fits, then step down
         if (rem_ff >= div_ff) begin
            rem_in = rem_ff - div_ff;
         end
         div_in = div_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done   = (cnt_ff == '0);
   assign result = neg_ff ? -$signed(rem_ff) : $signed(rem_ff);

endmodule

// File: hdl/odo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle.
module odo_cordic import odo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cordic_cmd_type        cmd,
   output logic                  done,
   output logic signed [XyW-1:0] cos_out,
   output logic signed [XyW-1:0] sin_out
);

   logic signed [XyW-1:0] x_ff, x_in;
   logic signed [XyW-1:0] y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic [IterW-1:0]      iter_ff, iter_in;
   logic                  run_ff, run_in;
   logic signed [XyW-1:0] x_sh, y_sh;
   logic signed [ZW-1:0]  atan_val;

   assign x_sh     = x_ff >>> iter_ff;
   assign y_sh     = y_ff >>> iter_ff;
   assign atan_val = $signed(ZW'(atan_at(AtanIdxW'(iter_ff))));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      run_in  = run_ff;
      if (cmd.start) begin
         x_in    = CordicStart;
         y_in    = '0;
         z_in    = cmd.angle;
         iter_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         // rotate toward zero residual angle
         if (z_ff >= 0) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IterW'(CordicLast)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
   end

   assign done    = !run_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;

endmodule

// File: hdl/diff_drive_odometry_unit.sv
// Channel   Direction  Carries
// req_if    in         func, right/left step counts, pose to load
// rsp_if    out        pose x/y (Q24.8 mm), heading (2^-16 rad), saturated flag
//
// Update transaction: MUL, PREP, MODA, FOLD1, FOLD2, ROT, MULX, RNDX, ADDX, ADDY, DONE from
// acceptance on; MODA waits on the 5-step remainder unit, ROT on the CORDIC and the heading remainder.
// Load transaction: LOAD waits on one pass of the remainder unit, then DONE.
// Reset is synchronous; it clears the pose to zero and empties the result register.
// A waiting result does not stop the next transaction; the sequencer only holds
// at its final state when the result register is still full.
module diff_drive_odometry_unit import odo_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   odo_req_if.sink   req_if,
   odo_rsp_if.source rsp_if
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_LOAD  = 13'b0000000000010,
      ST_MUL   = 13'b0000000000100,
      ST_PREP  = 13'b0000000001000,
      ST_MODA  = 13'b0000000010000,
      ST_FOLD1 = 13'b0000000100000,
      ST_FOLD2 = 13'b0000001000000,
      ST_ROT   = 13'b0000010000000,
      ST_MULX  = 13'b0000100000000,
      ST_RNDX  = 13'b0001000000000,
      ST_ADDX  = 13'b0010000000000,
      ST_ADDY  = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // operand and intermediate registers
   logic signed [StepW-1:0] r_ff, r_in;
   logic signed [StepW-1:0] l_ff, l_in;
   logic signed [DangW-1:0] dang_ff, dang_in;
   logic signed [SumPW-1:0] sump_ff, sump_in;
   logic signed [DistW-1:0] dist_ff, dist_in;
   logic signed [ModW-1:0]  hsum_ff, hsum_in;
   logic signed [AngW-1:0]  ang_ff, ang_in;
   logic                    neg_ff, neg_in;
   logic signed [XyW-1:0]   cos_ff, cos_in;
   logic signed [XyW-1:0]   sin_ff, sin_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [DispW-1:0] disp_ff, disp_in;
   logic                    sat_ff, sat_in;

   // pose state
   logic signed [PosW-1:0]  pose_x_ff, pose_x_in;
   logic signed [PosW-1:0]  pose_y_ff, pose_y_in;
   logic signed [HeadW-1:0] pose_h_ff, pose_h_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PosW-1:0]  rsp_x_ff, rsp_x_in;
   logic signed [PosW-1:0]  rsp_y_ff, rsp_y_in;
   logic signed [HeadW-1:0] rsp_h_ff, rsp_h_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   // remainder unit, shared by the angle and heading reductions, and CORDIC
   mod_cmd_type            mod_cmd;
   logic signed [ModW-1:0] mod_operand;
   logic                   mod_done;
   logic signed [ModW-1:0] mod_result;
   cordic_cmd_type         cordic_cmd;
   logic                   cordic_done;
   logic signed [XyW-1:0]  cordic_cos, cordic_sin;

   // datapath helpers
   logic signed [SumW-1:0]    diff, wsum;
   logic signed [DangW-1:0]   dang_mul;
   logic signed [SumPW-1:0]   sump_mul;
   logic signed [SumPW-1:0]   sump_rnd;
   logic signed [DangW-1:0]   dang_rnd, dang_half_num;
   logic signed [HStepW-1:0]  hstep;
   logic signed [ModW-1:0]    dir;
   logic                      fold1_hi, fold1_lo, fold2_hi, fold2_lo;
   logic signed [AngW-1:0]    fold1_ang, fold2_ang;
   logic signed [XyW-1:0]     mul_b;
   logic signed [ProdW-1:0]   prod_mul, prod_rnd;
   logic signed [DispW-1:0]   disp_val;
   logic signed [PosW-1:0]    add_base;
   logic signed [PosExtW-1:0] add_sum;
   logic                      add_ovf;
   logic signed [PosW-1:0]    add_clamped;

   logic req_acc;
   logic out_free;

   assign req_acc  = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // wheel difference and sum, scaled by the heading and distance gains
   assign diff     = SumW'(r_ff) - SumW'(l_ff);
   assign wsum     = SumW'(r_ff) + SumW'(l_ff);
   assign dang_mul = DangW'(diff) * DangW'(HeadStepK);
   assign sump_mul = SumPW'(wsum) * SumPW'(DistK);

   // round half away from zero: add half, minus one when negative, then floor
   assign sump_rnd = sump_ff + (SumPW'(1) <<< (DistShift - 1)) - SumPW'(sump_ff[SumPW-1]);
   assign dang_rnd = dang_ff + (DangW'(1) <<< (HeadFrac - 1)) - DangW'(dang_ff[DangW-1]);
   assign hstep    = HStepW'(dang_rnd >>> HeadFrac);

   // halve the heading change with truncation toward zero
   assign dang_half_num = dang_ff + DangW'(dang_ff[DangW-1]);
   assign dir = (ModW'(pose_h_ff) <<< HeadFrac) + ModW'(dang_half_num >>> 1);

   // fold into [-pi, pi], then into [-pi/2, pi/2] with a sign flip
   assign fold1_hi  = ang_ff > PiA;
   assign fold1_lo  = ang_ff < -PiA;
   assign fold1_ang = fold1_hi ? (ang_ff - TwoPiA) : (fold1_lo ? (ang_ff + TwoPiA) : ang_ff);
   assign fold2_hi  = ang_ff > HalfPiA;
   assign fold2_lo  = ang_ff < -HalfPiA;
   assign fold2_ang = fold2_hi ? (ang_ff - PiA) : (fold2_lo ? (ang_ff + PiA) : ang_ff);

   // one multiplier: distance times cosine, then distance times sine
   assign mul_b    = (state_ff == ST_MULX) ? cos_ff : sin_ff;
   assign prod_mul = ProdW'(dist_ff) * ProdW'(mul_b);
   assign prod_rnd = prod_ff + (ProdW'(1) <<< (DispShift - 1)) - ProdW'(prod_ff[ProdW-1]);
   assign disp_val = DispW'(prod_rnd >>> DispShift);

   // one adder with clamp for both coordinates
   assign add_base    = (state_ff == ST_ADDX) ? pose_x_ff : pose_y_ff;
   assign add_sum     = PosExtW'(add_base) + PosExtW'(disp_ff);
   assign add_ovf     = add_sum[PosW] ^ add_sum[PosW-1];
   assign add_clamped = add_ovf ? (add_sum[PosW] ? PosMin : PosMax) : add_sum[PosW-1:0];

   odo_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mod_cmd),
      .operand (mod_operand),
      .done    (mod_done),
      .result  (mod_result)
   );

   odo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cordic_cmd),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      l_in         = l_ff;
      dang_in      = dang_ff;
      sump_in      = sump_ff;
      dist_in      = dist_ff;
      hsum_in      = hsum_ff;
      ang_in       = ang_ff;
      neg_in       = neg_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      prod_in      = prod_ff;
      disp_in      = disp_ff;
      sat_in       = sat_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      pose_h_in    = pose_h_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_sat_in   = rsp_sat_ff;

      mod_cmd.start    = 1'b0;
      mod_cmd.sel      = MOD_HEADING;
      mod_operand      = hsum_ff;
      cordic_cmd.start = 1'b0;
      cordic_cmd.angle = ZW'(fold2_ang);

      // drop the result once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            mod_operand = ModW'(req_if.load_heading);
            if (req_acc) begin
               r_in   = req_if.right_steps;
               l_in   = req_if.left_steps;
               sat_in = 1'b0;
               if (req_if.func) begin
                  // load the position now, reduce the heading in the remainder unit
                  pose_x_in     = req_if.load_x;
                  pose_y_in     = req_if.load_y;
                  mod_cmd.start = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_LOAD: begin
            if (mod_done) begin
               pose_h_in = HeadW'(mod_result);
               state_in  = ST_DONE;
            end
         end
         ST_MUL: begin
            dang_in  = dang_mul;
            sump_in  = sump_mul;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // start reducing the direction angle
            dist_in       = DistW'(sump_rnd >>> DistShift);
            hsum_in       = ModW'(pose_h_ff) + ModW'(hstep);
            mod_cmd.start = 1'b1;
            mod_cmd.sel   = MOD_ANGLE;
            mod_operand   = dir;
            state_in      = ST_MODA;
         end
         ST_MODA: begin
            if (mod_done) begin
               // hand the unit over to the new heading
               ang_in        = AngW'(mod_result);
               mod_cmd.start = 1'b1;
               state_in      = ST_FOLD1;
            end
         end
         ST_FOLD1: begin
            ang_in   = fold1_ang;
            state_in = ST_FOLD2;
         end
         ST_FOLD2: begin
            neg_in           = fold2_hi || fold2_lo;
            cordic_cmd.start = 1'b1;
            state_in         = ST_ROT;
         end
         ST_ROT: begin
            if (cordic_done && mod_done) begin
               cos_in    = neg_ff ? -cordic_cos : cordic_cos;
               sin_in    = neg_ff ? -cordic_sin : cordic_sin;
               pose_h_in = HeadW'(mod_result);
               state_in  = ST_MULX;
            end
         end
         ST_MULX: begin
            prod_in  = prod_mul;
            state_in = ST_RNDX;
         end
         ST_RNDX: begin
            disp_in  = disp_val;
            prod_in  = prod_mul;
            state_in = ST_ADDX;
         end
         ST_ADDX: begin
            pose_x_in = add_clamped;
            sat_in    = sat_ff | add_ovf;
            disp_in   = disp_val;
            state_in  = ST_ADDY;
         end
         ST_ADDY: begin
            pose_y_in = add_clamped;
            sat_in    = sat_ff | add_ovf;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pose_x_ff;
               rsp_y_in     = pose_y_ff;
               rsp_h_in     = pose_h_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_h_ff    <= pose_h_in;
      end
      r_ff       <= r_in;
      l_ff       <= l_in;
      dang_ff    <= dang_in;
      sump_ff    <= sump_in;
      dist_ff    <= dist_in;
      hsum_ff    <= hsum_in;
      ang_ff     <= ang_in;
      neg_ff     <= neg_in;
      cos_ff     <= cos_in;
      sin_ff     <= sin_in;
      prod_ff    <= prod_in;
      disp_ff    <= disp_in;
      sat_ff     <= sat_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.pos_x     = rsp_x_ff;
   assign rsp_if.pos_y     = rsp_y_ff;
   assign rsp_if.heading   = rsp_h_ff;
   assign rsp_if.saturated = rsp_sat_ff;

endmodule

// File: hdl/odo_checker.sv
module odo_checker import odo_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [PosW-1:0]  rsp_pos_x,
   input logic signed [PosW-1:0]  rsp_pos_y,
   input logic signed [HeadW-1:0] rsp_heading,
   input logic                    rsp_saturated
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_heading) && $stable(rsp_saturated))
      else $error("result changed while stalled");

   // not ready in the cycle after taking a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("transaction taken on consecutive cycles");

   // no result without an outstanding transaction
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a transaction");

   // a clamped result sits at a range end
   a_sat_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_pos_x == PosMax || rsp_pos_x == PosMin
         || rsp_pos_y == PosMax || rsp_pos_y == PosMin)
      else $error("saturated flag without a clamped coordinate");

   // heading stays inside one turn
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading <= HeadMax && rsp_heading >= -HeadMax)
      else $error("heading outside one turn");

endmodule

bind diff_drive_odometry_unit odo_checker u_odo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_pos_x     (rsp_if.pos_x),
   .rsp_pos_y     (rsp_if.pos_y),
   .rsp_heading   (rsp_if.heading),
   .rsp_saturated (rsp_if.saturated)
);

// File: dv/diff_drive_odometry_unit_test.sv
module diff_drive_odometry_unit_test import odo_pkg::*; ();

   // Request codes carried on req_chan.func
   typedef enum logic {
      FUNC_UPDATE = 1'b0,
      FUNC_LOAD   = 1'b1
   } odo_func_type;

   // Receiver behavior, switched at random
   typedef enum logic [1:0] {
      RX_STEADY = 2'd0,
      RX_COIN   = 2'd1,
      RX_SPARSE = 2'd2
   } rx_mode_type;

   typedef struct {
      odo_func_type            func;
      logic signed [StepW-1:0] right_steps;
      logic signed [StepW-1:0] left_steps;
      logic signed [PosW-1:0]  load_x;
      logic signed [PosW-1:0]  load_y;
      logic signed [HeadW-1:0] load_heading;
   } motion_cmd_type;

   typedef struct {
      logic signed [PosW-1:0]  pos_x;
      logic signed [PosW-1:0]  pos_y;
      logic signed [HeadW-1:0] heading;
      logic                    saturated;
   } pose_type;

   // Fixed-point constants of the odometry math
   localparam longint HEAD_GAIN      = 64'sd2638337;     // 0.129/52.5 rad per step, 2^-30
   localparam longint TRAVEL_GAIN    = 64'sd1082130;     // 0.0645 mm per step, 2^-24
   localparam longint TWO_PI_HEAD    = 64'sd411775;      // 2*pi in heading units
   localparam longint ANGLE_PI       = 64'sd3373259426;  // pi in 2^-30 rad
   localparam longint ANGLE_TWO_PI   = 64'sd6746518852;
   localparam longint ANGLE_HALF_PI  = 64'sd1686629713;
   localparam longint UNIT_GAIN      = 64'sd652032874;   // gain-compensated unit vector
   localparam longint POS_TOP        = 64'sd2147483647;
   localparam longint POS_BOTTOM     = -64'sd2147483648;
   localparam int     ROTATION_STEPS = 16;
   localparam int     RANDOM_ITEMS   = 900;
   localparam int     REPORT_LIMIT   = 10;
   localparam int     STALL_LIMIT    = 3000;
   localparam int     LONG_HOLD      = 600;
   localparam int     DRAIN_CYCLES   = 48;

   // Arctangent of 2^-i in 2^-30 rad
   longint arctan_q30 [0:23] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
      64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
      64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
      64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
      64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
      64'sd1024,      64'sd512,       64'sd256,       64'sd128
   };

   logic clock = 1'b0;
   logic reset;

   odo_req_if req_chan ();
   odo_rsp_if rsp_chan ();

   diff_drive_odometry_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   always #4 clock = !clock;

   // Pose tracked alongside the block
   longint track_x;
   longint track_y;
   longint track_heading;

   motion_cmd_type motion_cmd_q [$];
   pose_type       pose_due_q [$];

   int          mismatch_count;
   int          cmds_accepted;
   int          idle_cycles;
   logic        req_taken;
   int          burst_left;
   int          gap_left;
   int          mode_left;
   int          hold_left;
   logic        long_hold_done;
   logic        ready_next;
   rx_mode_type rx_mode;
   motion_cmd_type next_cmd;

   // Divide by 2^s, rounding half away from zero
   function automatic longint round_shift(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) begin
         return (v + half) >>> s;
      end
      return -((-v + half) >>> s);
   endfunction

   // Rotation-mode CORDIC; fold the angle into [-pi/2, pi/2] first and
   // negate the vector when a half turn was taken out
   function automatic void direction_sin_cos(input longint angle, output longint cos_q30,
                                             output longint sin_q30);
      longint a;
      longint x;
      longint y;
      longint nx;
      logic   flip;
      int     i;
      a = angle % ANGLE_TWO_PI;
      if (a > ANGLE_PI) a -= ANGLE_TWO_PI;
      if (a < -ANGLE_PI) a += ANGLE_TWO_PI;
      flip = 1'b0;
      if (a > ANGLE_HALF_PI) begin
         a -= ANGLE_PI;
         flip = 1'b1;
      end else if (a < -ANGLE_HALF_PI) begin
         a += ANGLE_PI;
         flip = 1'b1;
      end
      x = UNIT_GAIN;
      y = 0;
      for (i = 0; i < ROTATION_STEPS; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            a -= arctan_q30[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            a += arctan_q30[i];
         end
         x = nx;
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
   endfunction

   // Apply one transaction to the tracked pose and return the pose it reports
   function automatic pose_type advance_pose(input motion_cmd_type cmd);
      pose_type res;
      longint   r;
      longint   l;
      longint   turn;
      longint   travel;
      longint   dir;
      longint   c;
      longint   s;
      longint   nx;
      longint   ny;
      res.saturated = 1'b0;
      if (cmd.func == FUNC_LOAD) begin
         track_x       = longint'(cmd.load_x);
         track_y       = longint'(cmd.load_y);
         track_heading = longint'(cmd.load_heading) % TWO_PI_HEAD;
      end else begin
         r      = longint'(cmd.right_steps);
         l      = longint'(cmd.left_steps);
         turn   = (r - l) * HEAD_GAIN;
         travel = round_shift((r + l) * TRAVEL_GAIN, 8);
         // Move along the mid-arc direction: old heading plus half the turn
         dir    = track_heading * 16384 + turn / 2;
         direction_sin_cos(dir, c, s);
         nx = track_x + round_shift(travel * c, 38);
         ny = track_y + round_shift(travel * s, 38);
         if (nx > POS_TOP) begin
            nx = POS_TOP;
            res.saturated = 1'b1;
         end else if (nx < POS_BOTTOM) begin
            nx = POS_BOTTOM;
            res.saturated = 1'b1;
         end
         if (ny > POS_TOP) begin
            ny = POS_TOP;
            res.saturated = 1'b1;
         end else if (ny < POS_BOTTOM) begin
            ny = POS_BOTTOM;
            res.saturated = 1'b1;
         end
         track_x       = nx;
         track_y       = ny;
         track_heading = (track_heading + round_shift(turn, 14)) % TWO_PI_HEAD;
      end
      res.pos_x   = track_x[PosW-1:0];
      res.pos_y   = track_y[PosW-1:0];
      res.heading = track_heading[HeadW-1:0];
      return res;
   endfunction

   // Queue an update; fill the load fields with noise since the block ignores them
   task automatic queue_update(input logic signed [StepW-1:0] r,
                               input logic signed [StepW-1:0] l);
      motion_cmd_type cmd;
      cmd.func         = FUNC_UPDATE;
      cmd.right_steps  = r;
      cmd.left_steps   = l;
      cmd.load_x       = $urandom;
      cmd.load_y       = $urandom;
      cmd.load_heading = HeadW'($urandom);
      motion_cmd_q.push_back(cmd);
   endtask

   // Queue a pose load; fill the step fields with noise
   task automatic queue_load(input logic signed [PosW-1:0] x, input logic signed [PosW-1:0] y,
                             input logic signed [HeadW-1:0] h);
      motion_cmd_type cmd;
      cmd.func         = FUNC_LOAD;
      cmd.right_steps  = StepW'($urandom);
      cmd.left_steps   = StepW'($urandom);
      cmd.load_x       = x;
      cmd.load_y       = y;
      cmd.load_heading = h;
      motion_cmd_q.push_back(cmd);
   endtask

   // Pick a step count: mostly small, sometimes full range or an extreme
   function automatic logic signed [StepW-1:0] pick_steps();
      logic signed [StepW-1:0] v;
      case ($urandom_range(0, 5))
         0, 1: begin
            v = StepW'($urandom_range(0, 400) - 200);
         end
         2: begin
            v = StepW'($urandom_range(0, 10000) - 5000);
         end
         3: begin
            v = StepW'($urandom);
         end
         4: begin
            case ($urandom_range(0, 4))
               0: v = 16'sh7fff;
               1: v = 16'sh8000;
               2: v = 16'sd1;
               3: v = -16'sd1;
               default: v = 16'sd0;
            endcase
         end
         default: begin
            v = StepW'($urandom_range(0, 60) - 30);
         end
      endcase
      return v;
   endfunction

   // Sender: hold each transaction until accepted, then advance to the next
   // one or insert a gap once the burst runs out
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (motion_cmd_q.size() > 0) begin
            next_cmd = motion_cmd_q.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.func         <= next_cmd.func;
            req_chan.right_steps  <= next_cmd.right_steps;
            req_chan.left_steps   <= next_cmd.left_steps;
            req_chan.load_x       <= next_cmd.load_x;
            req_chan.load_y       <= next_cmd.load_y;
            req_chan.load_heading <= next_cmd.load_heading;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1, 2: gap_left = $urandom_range(1, 8);
                  default: gap_left = $urandom_range(9, 45);
               endcase
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: switch between steady, coin-flip and sparse ready; once, after 150
   // requests are accepted, hold off long enough for the block to back up its input
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         ready_next = 1'b0;
      end else if (!long_hold_done && cmds_accepted >= 150) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         ready_next     = 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left = mode_left - 1;
         end
         case (rx_mode)
            RX_STEADY: ready_next = 1'b1;
            RX_COIN:   ready_next = 1'($urandom_range(0, 1));
            default:   ready_next = ($urandom_range(0, 7) == 0);
         endcase
      end
      rsp_chan.ready <= ready_next;
   end

   // Monitor: predict on each accepted request, check each accepted response
   // against the oldest prediction
   always @(posedge clock) begin
      pose_type       want;
      motion_cmd_type seen;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pose_due_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected response: x=%0d y=%0d heading=%0d sat=%0b",
                           rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.heading,
                           rsp_chan.saturated);
               end
            end else begin
               want = pose_due_q.pop_front();
               if (rsp_chan.pos_x !== want.pos_x || rsp_chan.pos_y !== want.pos_y ||
                   rsp_chan.heading !== want.heading ||
                   rsp_chan.saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("pose mismatch: expected x=%0d y=%0d heading=%0d sat=%0b",
                              want.pos_x, want.pos_y, want.heading, want.saturated);
                     $display("               actual   x=%0d y=%0d heading=%0d sat=%0b",
                              rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.heading,
                              rsp_chan.saturated);
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.func         = odo_func_type'(req_chan.func);
            seen.right_steps  = req_chan.right_steps;
            seen.left_steps   = req_chan.left_steps;
            seen.load_x       = req_chan.load_x;
            seen.load_y       = req_chan.load_y;
            seen.load_heading = req_chan.load_heading;
            pose_due_q.push_back(advance_pose(seen));
            cmds_accepted++;
         end
      end
   end

   // Watchdog: count cycles in which no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int                      n;
      int                      pick;
      logic signed [StepW-1:0] s;
      logic signed [PosW-1:0]  px;
      logic signed [PosW-1:0]  py;
      logic signed [HeadW-1:0] ph;

      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.func         = FUNC_UPDATE;
      req_chan.right_steps  = '0;
      req_chan.left_steps   = '0;
      req_chan.load_x       = '0;
      req_chan.load_y       = '0;
      req_chan.load_heading = '0;
      rsp_chan.ready        = 1'b0;
      track_x               = 0;
      track_y               = 0;
      track_heading         = 0;
      mismatch_count        = 0;
      cmds_accepted         = 0;
      idle_cycles           = 0;
      req_taken             = 1'b0;
      burst_left            = 0;
      gap_left              = 0;
      mode_left             = 0;
      hold_left             = 0;
      long_hold_done        = 1'b0;
      rx_mode               = RX_STEADY;

      // Directed: step extremes from the reset pose
      queue_update(16'sd0, 16'sd0);
      queue_update(16'sh7fff, 16'sh7fff);
      queue_update(16'sh8000, 16'sh8000);
      queue_update(16'sh7fff, 16'sh8000);
      queue_update(16'sh8000, 16'sh7fff);
      queue_update(16'sd1, -16'sd1);
      queue_update(-16'sd1, 16'sd1);
      queue_update(16'sd0, 16'sh7fff);
      queue_update(16'sh8000, 16'sd0);
      // Heading at the edges of its range, and loaded beyond it
      queue_load(32'sd0, 32'sd0, 20'sd411774);
      queue_update(16'sd1000, 16'sd1000);
      queue_load(32'sd0, 32'sd0, -20'sd411774);
      queue_load(32'sd0, 32'sd0, 20'sd524287);
      queue_load(32'sd0, 32'sd0, 20'sh80000);
      queue_load(32'sd0, 32'sd0, 20'sd411775);
      queue_load(32'sd0, 32'sd0, -20'sd411775);
      // Drive each coordinate past both ends of its range
      queue_load(32'sd2147483547, 32'sd0, 20'sd0);
      queue_update(16'sh7fff, 16'sh7fff);
      queue_load(32'sh80000000, 32'sd0, 20'sd205887);
      queue_update(16'sh7fff, 16'sh7fff);
      queue_load(32'sd0, 32'sd2147483000, 20'sd102944);
      queue_update(16'sd20000, 16'sd20000);
      queue_load(32'sd0, -32'sd2147483000, -20'sd102944);
      queue_update(16'sd20000, 16'sd20000);
      // Heading wraps across a full turn in both directions
      queue_load(32'sd0, 32'sd0, 20'sd411000);
      queue_update(16'sh7fff, 16'sh8000);
      queue_load(32'sd0, 32'sd0, -20'sd411000);
      queue_update(16'sh8000, 16'sh7fff);

      // Random: mostly updates with straight, spin and mixed wheel motion;
      // occasional loads, some near the range ends to provoke clamping
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 7) begin
            ph = ($urandom_range(0, 1) == 0) ? HeadW'($urandom_range(0, 823548) - 411774)
                                             : HeadW'($urandom);
            queue_load($urandom, $urandom, ph);
         end else if (pick < 11) begin
            px = ($urandom_range(0, 1) == 0) ? 32'sh7fffffff - $urandom_range(0, 2000000)
                                             : 32'sh80000000 + $urandom_range(0, 2000000);
            py = ($urandom_range(0, 1) == 0) ? 32'sh7fffffff - $urandom_range(0, 2000000)
                                             : 32'sh80000000 + $urandom_range(0, 2000000);
            queue_load(px, py, HeadW'($urandom_range(0, 823548) - 411774));
         end else if (pick < 30) begin
            s = pick_steps();
            queue_update(s, s);
         end else if (pick < 42) begin
            s = pick_steps();
            queue_update(s, -s);
         end else if (pick < 50) begin
            s = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
            queue_update(s, StepW'(s - $urandom_range(0, 3000)));
         end else begin
            queue_update(pick_steps(), pick_steps());
         end
      end

      // Release reset away from the sampling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: wait until every request is in and every response checked;
      // look at the rising edge, where the sender's outputs are settled
      while (motion_cmd_q.size() != 0 || req_chan.valid || pose_due_q.size() != 0) begin
         @(posedge clock);
      end
      // Allow a full update latency for any stray response
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (pose_due_q.size() != 0) begin
         mismatch_count += pose_due_q.size();
         $display("%0d responses never arrived", pose_due_q.size());
      end
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
